FILE: sv/acs_pkg.sv
package acs_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_STANDBY_TICKS = 3'd0;
  localparam logic [2:0] REG_AVERAGE_TICKS = 3'd1;
  localparam logic [2:0] REG_CURRENT_GAIN  = 3'd2;
  localparam logic [2:0] REG_VOLTAGE_GAIN  = 3'd3;
  localparam logic [2:0] REG_CURRENT_TRIM  = 3'd4;

  // Result mode codes.
  localparam logic [1:0] MODE_STANDBY   = 2'd0;
  localparam logic [1:0] MODE_ACCUM     = 2'd1;
  localparam logic [1:0] MODE_AVERAGING = 2'd2;
  localparam logic [1:0] MODE_SCALED    = 2'd3;

  localparam int CFG_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int OUT_W     = 176;
  localparam int INV_W     = 25;
  localparam int CNT_W     = 16;
  localparam int DSR_W     = 32;
  // The reciprocal divides 2^40 by a value of at least 2^16: 25 quotient bits.
  localparam int INV_STEPS = 25;
  localparam int INV_REM0  = 15;

  typedef struct packed {
    logic start;
    logic recip;
  } div_cmd_t;

endpackage

FILE: sv/adc_offset_calibrate_and_scale_unit.sv
// ADC offset calibration and scaling, one item per control tick. After reset the
// unit passes standby_ticks items in mode 0, then sums average_ticks samples per
// phase in mode 1, then on one item (mode 2) divides each sum by average_ticks to
// get a Q12.8 offset. Every later item gives the phase currents
// gain*(raw-offset)+trim and the bus voltage in Q16.16, saturated, the voltage
// reciprocal in Q1.24 and a wrapping count. The averaging item runs the shared
// restoring divider once per phase, and it retires one quotient bit a cycle. A
// scaled item makes four passes through the single multiplier, each a multiply
// state and a post state, then 25 divider steps for the reciprocal. The input is
// not ready while an item is in work.
module adc_offset_calibrate_and_scale_unit #(
  parameter int ADC_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [acs_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // phase_a_raw, phase_b_raw, phase_c_raw, bus_voltage_raw, zero fill
  input  logic [((4*ADC_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // phase_a_current, phase_b_current, phase_c_current, bus_voltage,
  // bus_voltage_inverse, scaled_count, zero fill
  output logic [acs_pkg::OUT_W-1:0]        m_axis_tdata_o,
  // mode
  output logic [1:0]                       m_axis_tuser_o
);
  import acs_pkg::*;

  localparam int RAW_W  = ADC_BITS;
  localparam int SUM_W  = ADC_BITS + 16;
  localparam int OFF_W  = ADC_BITS + 8;
  localparam int DVD_W  = ADC_BITS + 24;
  localparam int DIFF_W = ADC_BITS + 10;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int TC_W   = 17;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVST = 3'd1;
  localparam logic [2:0] S_DIVW  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_INVST = 3'd5;
  localparam logic [2:0] S_INVW  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Configuration.
  logic [15:0]       standby_q, average_q;
  logic [GAIN_W-1:0] cgain_q, vgain_q;
  logic [31:0]       trim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      standby_q <= 16'd1000;
      average_q <= 16'd5000;
      cgain_q   <= '0;
      vgain_q   <= '0;
      trim_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STANDBY_TICKS: standby_q <= cfg_data_i[15:0];
        REG_AVERAGE_TICKS: average_q <= cfg_data_i[15:0];
        REG_CURRENT_GAIN:  cgain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_VOLTAGE_GAIN:  vgain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_CURRENT_TRIM:  trim_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [2:0]        state_q;
  logic [1:0]        idx_q;
  logic              cal_q;
  logic [TC_W-1:0]   tc_q;
  logic [SUM_W-1:0]  sum_q [3];
  logic [OFF_W-1:0]  off_q [3];
  logic [CNT_W-1:0]  scaled_q;
  logic [RAW_W-1:0]  raw_q [4];
  logic signed [PROD_W-1:0] prod_q;

  logic [1:0]        mode_q;
  logic [31:0]       cur_q [3];
  logic [31:0]       volt_q;
  logic [INV_W-1:0]  inv_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;
  logic [1:0]        out_user_q;

  div_cmd_t          div_cmd;
  logic [DVD_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;

  logic              in_acc;
  logic [RAW_W-1:0]  in_raw [4];
  logic [TC_W-1:0]   limit_sb, limit_av;

  logic [OFF_W-1:0]          sel_off;
  logic signed [DIFF_W-1:0]  op_a;
  logic signed [GAIN_W:0]    op_b;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [ACC_W-1:0]   acc;
  logic [31:0]               cur_sat;
  logic [31:0]               volt_sat;
  logic [OFF_W-1:0]          off_sat;
  logic                      finish_out;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar g = 0; g < 4; g++) begin : g_raw
    assign in_raw[g] = s_axis_tdata_i[g*RAW_W +: RAW_W];
  end

  assign limit_sb = {1'b0, standby_q};
  assign limit_av = {1'b0, standby_q} + {1'b0, average_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (idx_q)
      2'd0:    sel_off = off_q[0];
      2'd1:    sel_off = off_q[1];
      2'd2:    sel_off = off_q[2];
      default: sel_off = '0;
    endcase
    if (idx_q == 2'd3) begin
      op_a = $signed({{(DIFF_W-RAW_W){1'b0}}, raw_q[3]});
      op_b = $signed({1'b0, vgain_q});
    end else begin
      op_a = $signed({2'b00, raw_q[idx_q], 8'd0}) - $signed({2'b00, sel_off});
      op_b = $signed({1'b0, cgain_q});
    end
  end

  // Floor to Q16.16, add the trim, saturate to 32 bits.
  assign prod_sh = prod_q >>> 8;
  assign acc     = ACC_W'(prod_sh) + ACC_W'($signed(trim_q));
  always_comb begin
    if (acc[ACC_W-1:31] == '0 || acc[ACC_W-1:31] == '1) begin
      cur_sat = acc[31:0];
    end else if (acc[ACC_W-1]) begin
      cur_sat = 32'h8000_0000;
    end else begin
      cur_sat = 32'h7FFF_FFFF;
    end
    volt_sat = (|prod_q[PROD_W-1:32]) ? 32'hFFFF_FFFF : prod_q[31:0];
    off_sat  = (|div_quo[DVD_W-1:OFF_W]) ? '1 : div_quo[OFF_W-1:0];
  end

  always_comb begin
    div_cmd.start = (state_q == S_DIVST) || (state_q == S_INVST);
    div_cmd.recip = (state_q == S_INVST);
    div_dvd       = {sum_q[idx_q[1] ? 2 : (idx_q[0] ? 1 : 0)], 8'd0};
    if (state_q == S_INVST) begin
      div_dsr = (volt_q < 32'h0001_0000) ? 32'h0001_0000 : volt_q;
    end else begin
      div_dsr = {16'd0, average_q};
    end
  end

  acs_div #(.DVD_W(DVD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  assign finish_out = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      cal_q    <= 1'b0;
      tc_q     <= '0;
      scaled_q <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            idx_q <= '0;
            if (cal_q) begin
              state_q <= S_MUL;
            end else if (tc_q < limit_sb) begin
              tc_q    <= tc_q + 1'b1;
              state_q <= S_DONE;
            end else if (tc_q < limit_av) begin
              for (int i = 0; i < 3; i++) begin
                sum_q[i] <= sum_q[i] + SUM_W'(in_raw[i]);
              end
              tc_q    <= tc_q + 1'b1;
              state_q <= S_DONE;
            end else if (average_q == '0) begin
              for (int i = 0; i < 3; i++) begin
                sum_q[i] <= '0;
                off_q[i] <= '0;
              end
              tc_q    <= '0;
              cal_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIVST;
            end
          end
        end
        S_DIVST: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            off_q[idx_q] <= off_sat;
            if (idx_q == 2'd2) begin
              for (int i = 0; i < 3; i++) begin
                sum_q[i] <= '0;
              end
              tc_q    <= '0;
              cal_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_DIVST;
            end
          end
        end
        S_MUL: state_q <= S_POST;
        S_POST: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= (idx_q == 2'd3) ? S_INVST : S_MUL;
        end
        S_INVST: state_q <= S_INVW;
        S_INVW: begin
          if (div_done) begin
            scaled_q <= scaled_q + 1'b1;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Work registers for one item's results.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        raw_q[i] <= in_raw[i];
      end
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0;
      end
      volt_q <= '0;
      inv_q  <= '0;
      cnt_q  <= '0;
      if (cal_q) begin
        mode_q <= MODE_SCALED;
      end else if (tc_q < limit_sb) begin
        mode_q <= MODE_STANDBY;
      end else if (tc_q < limit_av) begin
        mode_q <= MODE_ACCUM;
      end else begin
        mode_q <= MODE_AVERAGING;
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(op_a * op_b);
    end
    if (state_q == S_POST) begin
      if (idx_q == 2'd3) begin
        volt_q <= volt_sat;
      end else begin
        cur_q[idx_q] <= cur_sat;
      end
    end
    if (state_q == S_INVW && div_done) begin
      inv_q <= div_quo[INV_W-1:0];
      cnt_q <= scaled_q + 1'b1;
    end
  end

  // Output register: holds a finished item while the next one is taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_out) begin
      out_data_q <= {7'd0, cnt_q, inv_q, volt_q, cur_q[2], cur_q[1], cur_q[0]};
      out_user_q <= mode_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

FILE: sv/acs_div.sv
module acs_div #(
  parameter int DVD_W = 36
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  acs_pkg::div_cmd_t        cmd_i,
  input  logic [DVD_W-1:0]         dividend_i,
  input  logic [acs_pkg::DSR_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [DVD_W-1:0]         quot_o
);
  import acs_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic             run_q;
  logic [STEP_W-1:0] step_q;
  logic [DSR_W:0]   rem_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic             done_q;

  logic [DSR_W:0]   rem_sh;
  logic             ge;

  // One restoring step per cycle.
  assign rem_sh = {rem_q[DSR_W-1:0], dvd_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q  <= 1'b1;
        step_q <= cmd_i.recip ? STEP_W'(INV_STEPS) : STEP_W'(DVD_W);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dsr_q <= divisor_i;
      quo_q <= '0;
      if (cmd_i.recip) begin
        rem_q <= (DSR_W+1)'(1) << INV_REM0;
        dvd_q <= '0;
      end else begin
        rem_q <= '0;
        dvd_q <= dividend_i;
      end
    end else if (run_q) begin
      rem_q <= ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: tb/adc_offset_calibrate_and_scale_unit_test.sv
`timescale 1ns / 100ps

module adc_offset_calibrate_and_scale_unit_test;
  import acs_pkg::*;

  localparam int ADC_BITS = 12;
  localparam int IN_W     = ((4*ADC_BITS+7)/8)*8;
  localparam int MAX_CYC  = 1500000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ia;
    logic [31:0] ib;
    logic [31:0] ic;
    logic [31:0] vbus;
    logic [24:0] vinv;
    logic [15:0] cnt;
  } sample_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic [1:0]        m_axis_tuser_o;

  adc_offset_calibrate_and_scale_unit #(.ADC_BITS(ADC_BITS)) DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the registers and calibration state.
  logic [15:0]        standby_r, average_r;
  logic [23:0]        igain_r, vgain_r;
  logic signed [31:0] itrim_r;
  logic               calib_done;
  logic [16:0]        ticks;
  logic [27:0]        acc_sum [3];
  logic [19:0]        offs [3];
  logic [15:0]        scaled_cnt;

  sample_out_t expected_q [$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_off = 1'b0;
  bit  rx_random = 1'b1;

  task automatic shadow_reset();
    standby_r = 16'd1000; average_r = 16'd5000;
    igain_r = '0; vgain_r = '0; itrim_r = '0;
    calib_done = 1'b0; ticks = '0; scaled_cnt = '0;
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = '0;
      offs[i] = '0;
    end
  endtask

  function automatic logic [31:0] phase_current(logic [11:0] raw, logic [19:0] off);
    longint diff, prod, v;
    diff = longint'({raw, 8'd0}) - longint'(off);
    prod = diff * longint'(igain_r);
    v = (prod >>> 8) + longint'(itrim_r);
    if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
    if (v < -64'sh80000000) v = -64'sh80000000;
    return v[31:0];
  endfunction

  function automatic sample_out_t predict_tick(logic [11:0] raw [4]);
    sample_out_t r;
    longint unsigned v, vc, off;
    r = '0;
    if (!calib_done) begin
      if (ticks < {1'b0, standby_r}) begin
        r.mode = MODE_STANDBY;
        ticks++;
      end else if (ticks < 17'(standby_r) + 17'(average_r)
                   && 32'(ticks) < 32'(standby_r) + 32'(average_r)) begin
        r.mode = MODE_ACCUM;
        for (int i = 0; i < 3; i++) acc_sum[i] = acc_sum[i] + 28'(raw[i]);
        ticks++;
      end else begin
        r.mode = MODE_AVERAGING;
        for (int i = 0; i < 3; i++) begin
          off = 0;
          if (average_r != 0) off = (longint'(acc_sum[i]) << 8) / average_r;
          if (off > 64'hFFFFF) off = 64'hFFFFF;
          offs[i] = off[19:0];
          acc_sum[i] = '0;
        end
        ticks = '0;
        calib_done = 1'b1;
      end
      return r;
    end
    r.mode = MODE_SCALED;
    r.ia = phase_current(raw[0], offs[0]);
    r.ib = phase_current(raw[1], offs[1]);
    r.ic = phase_current(raw[2], offs[2]);
    v = longint'(raw[3]) * vgain_r;
    if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
    r.vbus = v[31:0];
    vc = (v < 65536) ? 65536 : v;
    r.vinv = 25'((64'd1 << 40) / vc);
    scaled_cnt++;
    r.cnt = scaled_cnt;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STANDBY_TICKS: standby_r = val[15:0];
      REG_AVERAGE_TICKS: average_r = val[15:0];
      REG_CURRENT_GAIN:  igain_r = val[23:0];
      REG_VOLTAGE_GAIN:  vgain_r = val[23:0];
      REG_CURRENT_TRIM:  itrim_r = val;
      default: ;
    endcase
  endtask

  // The valid stays high after the accepting edge; drain(), or a next call that
  // inserts a gap, drops it at the following falling edge.
  task automatic send_tick(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                           logic [11:0] vb, bit gaps = 1'b1);
    logic [11:0] raw [4];
    int g;
    raw[0] = a; raw[1] = b; raw[2] = c; raw[3] = vb;
    g = 0;
    if (gaps) g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                 : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    @(negedge clk_i);
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {vb, c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.push_back(predict_tick(raw));
  endtask

  task automatic rand_tick(bit gaps = 1'b1);
    send_tick(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), gaps);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Restarting calibration needs a reset, which is allowed only once, so the
  // calibration corners go first with small counts and scaling follows.
  task automatic test_calibration();
    write_reg(REG_STANDBY_TICKS, 32'd3);
    write_reg(REG_AVERAGE_TICKS, 32'd4);
    write_reg(REG_CURRENT_GAIN, 32'h010000);
    write_reg(REG_VOLTAGE_GAIN, 32'h000100);
    write_reg(REG_CURRENT_TRIM, 32'h0);
    send_tick(12'd0, 12'd0, 12'd0, 12'd0);
    send_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_tick(12'h555, 12'hAAA, 12'h123, 12'h800);
    send_tick(12'hFFF, 12'h000, 12'h801, 12'h7FF);
    send_tick(12'h000, 12'hFFF, 12'h7FE, 12'h001);
    send_tick(12'hABC, 12'h001, 12'hFFF, 12'hFFF);
    send_tick(12'h7FF, 12'h800, 12'h3FF, 12'h000);
    // Averaging tick.
    send_tick(12'h000, 12'h000, 12'h000, 12'h000);
    drain();
  endtask

  task automatic test_scaling_extremes();
    send_tick(12'h000, 12'hFFF, 12'h800, 12'h000);
    send_tick(12'hFFF, 12'h000, 12'h001, 12'hFFF);
    drain();
    write_reg(REG_CURRENT_GAIN, 32'hFFFFFF);
    write_reg(REG_VOLTAGE_GAIN, 32'hFFFFFF);
    write_reg(REG_CURRENT_TRIM, 32'h7FFFFFFF);
    send_tick(12'hFFF, 12'h000, 12'h800, 12'hFFF);
    send_tick(12'h000, 12'hFFF, 12'h7FF, 12'h001);
    drain();
    write_reg(REG_CURRENT_TRIM, 32'h80000000);
    send_tick(12'h000, 12'hFFF, 12'h000, 12'h000);
    send_tick(12'hFFF, 12'h000, 12'hFFF, 12'h010);
    drain();
    write_reg(REG_CURRENT_GAIN, 32'h0);
    write_reg(REG_VOLTAGE_GAIN, 32'h0000FF);
    write_reg(REG_CURRENT_TRIM, 32'hFFFF8000);
    send_tick(12'h123, 12'h456, 12'h789, 12'h101);
    send_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    drain();
    // Registers that calibration would read are still rewritten; no effect now.
    write_reg(REG_STANDBY_TICKS, 32'hFFFF);
    write_reg(REG_AVERAGE_TICKS, 32'h0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (30) rand_tick(1'b0);
    join
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_CURRENT_GAIN, ph == 0 ? 32'hFFFFFF : {8'd0, 24'($urandom)} >> $urandom_range(0, 16));
      write_reg(REG_VOLTAGE_GAIN, ph == 1 ? 32'h0 : {8'd0, 24'($urandom)} >> $urandom_range(0, 16));
      write_reg(REG_CURRENT_TRIM, $urandom);
      rx_random = (ph != 3);
      repeat (95) rand_tick(ph != 2);
      drain();
    end
    rx_random = 1'b1;
  endtask

  // Output side: stalls and result checking.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready_i <= 1'b0;
    else if (!rx_random) m_axis_tready_i <= 1'b1;
    else case ($urandom_range(0, 19))
      0:       m_axis_tready_i <= 1'b0;
      1, 2, 3: m_axis_tready_i <= ~m_axis_tready_i;
      default: m_axis_tready_i <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    sample_out_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.mode = m_axis_tuser_o;
      {got.cnt, got.vinv, got.vbus, got.ic, got.ib, got.ia} = m_axis_tdata_o[168:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result mode=%0d data=%h", $time, got.mode,
                 m_axis_tdata_o);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.mode != exp_r.mode) begin
          errors++;
          $display("%0t: mode exp %0d got %0d", $time, exp_r.mode, got.mode);
        end
        if (got.ia != exp_r.ia) begin
          errors++;
          $display("%0t: phase_a exp %h got %h", $time, exp_r.ia, got.ia);
        end
        if (got.ib != exp_r.ib) begin
          errors++;
          $display("%0t: phase_b exp %h got %h", $time, exp_r.ib, got.ib);
        end
        if (got.ic != exp_r.ic) begin
          errors++;
          $display("%0t: phase_c exp %h got %h", $time, exp_r.ic, got.ic);
        end
        if (got.vbus != exp_r.vbus) begin
          errors++;
          $display("%0t: bus_voltage exp %h got %h", $time, exp_r.vbus, got.vbus);
        end
        if (got.vinv != exp_r.vinv) begin
          errors++;
          $display("%0t: inverse exp %h got %h", $time, exp_r.vinv, got.vinv);
        end
        if (got.cnt != exp_r.cnt) begin
          errors++;
          $display("%0t: count exp %0d got %0d", $time, exp_r.cnt, got.cnt);
        end
      end
    end
    if (cycles == MAX_CYC) begin
      $display("** adc_offset_calibrate_and_scale_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_calibration();
    test_scaling_extremes();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0)
      $display("** adc_offset_calibrate_and_scale_unit: PASSED **");
    else
      $display("** adc_offset_calibrate_and_scale_unit: FAILED **");
    $finish;
  end

endmodule
